/* rtl/core/rsv_pkg.sv */
// Shared types, constants and GF(2^8) helpers for the Vandermonde parity block.
`default_nettype none
package rsv_pkg;

    localparam int DATA_LANES   = 8;
    localparam int PARITY_LANES = 4;
    localparam int BYTE_W       = 8;

    localparam int DEF_MAX_DATA_SHARDS   = 8;
    localparam int DEF_MAX_PARITY_SHARDS = 4;

    // Reduction polynomial x^8 + x^4 + x^3 + x^2 + 1.
    localparam logic [8:0] GF_POLY = 9'h11d;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DATA_COUNT   = 2'd0,
        CFG_PARITY_COUNT = 2'd1,
        CFG_VERIFY_MODE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DATA_LANES*BYTE_W-1:0]   data_column;
        logic [PARITY_LANES*BYTE_W-1:0] stored_parity_column;
        logic                           column_last;
    } col_word_t;

    typedef struct packed {
        logic [PARITY_LANES*BYTE_W-1:0] parity_column;
        logic                           column_mismatch;
        logic                           result_last;
    } par_word_t;

    // Carry-less product reduced by the field polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        acc = 8'h00;
        x   = a;
        y   = b;
        for (int n = 0; n < BYTE_W; n++)
        begin
            if (y[0])
            begin
                acc = acc ^ x;
            end
            y = y >> 1;
            if (x[7])
            begin
                x = (x << 1) ^ GF_POLY[7:0];
            end
            else
            begin
                x = x << 1;
            end
        end
        return acc;
    endfunction

    // Vandermonde coefficient (row+1)^lane.
    function automatic logic [7:0] gf_coeff(input int row, input int lane);
        logic [7:0] c;
        logic [7:0] base;
        c    = 8'h01;
        base = 8'(row + 1);
        for (int n = 0; n < DATA_LANES; n++)
        begin
            if (n < lane)
            begin
                c = gf_mul(c, base);
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/rs_vandermonde_parity_gf256.sv */
// Reed-Solomon Vandermonde parity over GF(2^8): one byte column in, one parity word out.
// A column word passes through the s1, s2, s3 and output registers to its parity word on the output.
// Throughput: one column per cycle; each of the four stages holds one word and the
// stages advance independently, so a stalled output only backs up the pipe once full.
// Stages: lane masking, constant GF products, XOR reduction, compare and output register.
// Reset clears the valid bits and sets data_count 1, parity_count 1, verify_mode 0.
`default_nettype none
module rs_vandermonde_parity_gf256 #(
    parameter int MAX_DATA_SHARDS   = rsv_pkg::DEF_MAX_DATA_SHARDS,
    parameter int MAX_PARITY_SHARDS = rsv_pkg::DEF_MAX_PARITY_SHARDS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_wr_en,
    input  wire logic [rsv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rsv_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                            col_valid,
    output logic                                 col_stall,
    input  wire rsv_pkg::col_word_t              col_word,

    output logic                                 par_valid,
    input  wire logic                            par_stall,
    output rsv_pkg::par_word_t                   par_word
);

    localparam int DL = (MAX_DATA_SHARDS < rsv_pkg::DATA_LANES) ?
                        MAX_DATA_SHARDS : rsv_pkg::DATA_LANES;
    localparam int PL = (MAX_PARITY_SHARDS < rsv_pkg::PARITY_LANES) ?
                        MAX_PARITY_SHARDS : rsv_pkg::PARITY_LANES;

    // Configuration registers.
    logic [3:0] dc_reg;
    logic [2:0] pc_reg;
    logic       vm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg <= 4'd1;
            pc_reg <= 3'd1;
            vm_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rsv_pkg::CFG_DATA_COUNT:   dc_reg <= cfg_data[3:0];
                rsv_pkg::CFG_PARITY_COUNT: pc_reg <= cfg_data[2:0];
                rsv_pkg::CFG_VERIFY_MODE:  vm_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Pipeline registers.
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [DL-1:0][7:0]      s1_data_reg;
    logic [PL-1:0][7:0]      s1_stored_reg, s2_stored_reg, s3_stored_reg;
    logic [PL-1:0]           s1_pmask_reg, s2_pmask_reg, s3_pmask_reg;
    logic                    s1_verify_reg, s2_verify_reg, s3_verify_reg;
    logic                    s1_last_reg, s2_last_reg, s3_last_reg;
    logic [PL-1:0][DL-1:0][7:0] s2_prod_reg;
    logic [PL-1:0][7:0]      s3_par_reg;
    rsv_pkg::par_word_t      out_reg;

    logic [DL-1:0][7:0]         s1_data_next;
    logic [PL-1:0][7:0]         s1_stored_next;
    logic [PL-1:0]              s1_pmask_next;
    logic [PL-1:0][DL-1:0][7:0] s2_prod_next;
    logic [PL-1:0][7:0]         s3_par_next;
    rsv_pkg::par_word_t         out_next;

    // A stage takes a new word when it is empty or its word moves on.
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !out_valid_reg || !par_stall;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;

    assign col_stall = !rdy1;
    assign par_valid = out_valid_reg;
    assign par_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= col_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage 1: drop data lanes at or above the data count, select used parity lanes.
    always_comb
    begin
        for (int j = 0; j < DL; j++)
        begin
            s1_data_next[j] = (dc_reg > 4'(j)) ?
                              col_word.data_column[8*j +: 8] : 8'h00;
        end
        for (int i = 0; i < PL; i++)
        begin
            s1_stored_next[i] = col_word.stored_parity_column[8*i +: 8];
            s1_pmask_next[i]  = (pc_reg > 3'(i));
        end
    end

    // Stage 2: constant-coefficient products.
    rsv_gf_matrix #(
        .DL (DL),
        .PL (PL)
    ) u_matrix (
        .data_lanes (s1_data_reg),
        .products   (s2_prod_next)
    );

    // Stage 3: XOR reduction per parity row; unused rows give zero.
    always_comb
    begin
        for (int i = 0; i < PL; i++)
        begin
            s3_par_next[i] = 8'h00;
            for (int j = 0; j < DL; j++)
            begin
                s3_par_next[i] = s3_par_next[i] ^ s2_prod_reg[i][j];
            end
            if (!s2_pmask_reg[i])
            begin
                s3_par_next[i] = 8'h00;
            end
        end
    end

    // Stage 4: in verify mode, compare used rows against the stored parity.
    always_comb
    begin
        out_next                 = '0;
        out_next.result_last     = s3_last_reg;
        for (int i = 0; i < PL; i++)
        begin
            out_next.parity_column[8*i +: 8] = s3_par_reg[i];
            if (s3_verify_reg && s3_pmask_reg[i] && (s3_par_reg[i] != s3_stored_reg[i]))
            begin
                out_next.column_mismatch = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_data_reg   <= s1_data_next;
            s1_stored_reg <= s1_stored_next;
            s1_pmask_reg  <= s1_pmask_next;
            s1_verify_reg <= vm_reg;
            s1_last_reg   <= col_word.column_last;
        end
        if (rdy2)
        begin
            s2_prod_reg   <= s2_prod_next;
            s2_stored_reg <= s1_stored_reg;
            s2_pmask_reg  <= s1_pmask_reg;
            s2_verify_reg <= s1_verify_reg;
            s2_last_reg   <= s1_last_reg;
        end
        if (rdy3)
        begin
            s3_par_reg    <= s3_par_next;
            s3_stored_reg <= s2_stored_reg;
            s3_pmask_reg  <= s2_pmask_reg;
            s3_verify_reg <= s2_verify_reg;
            s3_last_reg   <= s2_last_reg;
        end
        if (rdy4)
        begin
            out_reg <= out_next;
        end
    end

    // Stage 3 rows outside the parity count, kept for the zero check below.
    logic [PL-1:0][7:0] s3_unused_rows;

    always_comb
    begin
        for (int i = 0; i < PL; i++)
        begin
            s3_unused_rows[i] = s3_pmask_reg[i] ? 8'h00 : s3_par_reg[i];
        end
    end

    // The input is held off only when every stage holds a word.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        col_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg))
        else $error("input stalled while the pipeline has a bubble");

    // A word leaving stage 3 shows up on the output with its last flag.
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && rdy4) |=> (par_valid && (par_word.result_last == $past(s3_last_reg))))
        else $error("result word lost or last flag changed");

    // Encode-mode words never report a mismatch.
    a_encode_no_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && rdy4 && !s3_verify_reg) |=> !par_word.column_mismatch)
        else $error("mismatch flagged outside verify mode");

    // Rows outside the parity count reduce to zero.
    a_unused_rows_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_unused_rows == '0))
        else $error("unused parity row is not zero");

endmodule
`default_nettype wire

/* rtl/core/rsv_gf_matrix.sv */
// Constant-coefficient GF(2^8) product matrix: every data byte times every row coefficient.
`default_nettype none
module rsv_gf_matrix #(
    parameter int DL = rsv_pkg::DATA_LANES,
    parameter int PL = rsv_pkg::PARITY_LANES
) (
    input  wire logic [DL-1:0][7:0]         data_lanes,
    output logic      [PL-1:0][DL-1:0][7:0] products
);

    for (genvar i = 0; i < PL; i++)
    begin : g_row
        for (genvar j = 0; j < DL; j++)
        begin : g_lane
            localparam logic [7:0] COEFF = rsv_pkg::gf_coeff(i, j);
            // With a constant coefficient this folds into a small XOR network.
            assign products[i][j] = rsv_pkg::gf_mul(COEFF, data_lanes[j]);
        end
    end

endmodule
`default_nettype wire
